@@ hw/rtl/blit_pkg.sv @@
// Shared types and constants of the band-limited impulse train block.
`default_nettype none

package blit_pkg;

    localparam int FREQ_W     = 19;
    localparam int SPS_W      = 20;
    localparam int HARM_W     = 10;
    localparam int THR_W      = 15;
    localparam int SAMPLE_W   = 16;
    localparam int SINE_W     = 15;
    localparam int MULT_W     = HARM_W + 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SECONDS_PER_SAMPLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_COUNT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEAR_ZERO_THRESHOLD = 2'd2;

    localparam logic [SPS_W-1:0]  SPS_RESET  = 20'd89478;
    localparam logic [HARM_W-1:0] HARM_RESET = 10'd0;
    localparam logic [THR_W-1:0]  THR_RESET  = 15'd1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ANGLE,
        ST_LOOK_NUM,
        ST_INC,
        ST_PHASE,
        ST_DIV,
        ST_DONE
    } blit_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bandlimited_impulse_train.sv @@
// Band-limited impulse train: one frequency word in, one Q1.15 sample word out.
// The divide is skipped when the output is forced to one; a new input word is taken
// only once the previous sample has been loaded into the output register.
// The time is set by the restoring divider, which makes one quotient bit per cycle,
// and by one shared multiplier and one registered sine ROM port used in turn.
// Reset (aresetn low, synchronous) clears the phase, loads the register defaults and
// drops the output word; the sine ROM is a constant table and needs no clearing.
`default_nettype none

module bandlimited_impulse_train #(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [blit_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [blit_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // Fields from bit 0: frequency[18:0], zero padding[23:19].
    input  wire logic [blit_pkg::S_TDATA_W-1:0]      s_tdata,
    // Output stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // Fields from bit 0: sample[15:0].
    output logic [blit_pkg::M_TDATA_W-1:0]           m_tdata
);

    import blit_pkg::*;

    localparam int TBL_N   = 1 << SINE_TABLE_BITS;
    localparam int ADDR_W  = SINE_TABLE_BITS + 1;
    localparam int MA_W    = FREQ_W;
    localparam int MB_W    = (SPS_W > PHASE_BITS + 1) ? SPS_W : PHASE_BITS + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int INC_LSB = 36 - PHASE_BITS;
    localparam int DIVR_W  = MULT_W + SINE_W;
    localparam int DVD_W   = SINE_W + 15;
    localparam int CNT_W   = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);
    localparam logic [ADDR_W:0]  TBL_N_X   = (ADDR_W + 1)'(TBL_N);
    localparam logic [ADDR_W:0]  TWO_N_X   = (ADDR_W + 1)'(2 * TBL_N);

    typedef logic [SINE_W-1:0] rom_t [0:TBL_N];

    // Shift-and-subtract quotient, used only while the ROM contents are built.
    function automatic longint unsigned div_small(input longint unsigned dividend,
                                                  input longint unsigned divisor);
        longint unsigned quo;
        longint unsigned rem;
        int b;
        quo = 0;
        rem = 0;
        for (b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((dividend >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= divisor) begin
                rem = rem - divisor;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint sum;
        int k;
        int n;
        for (k = 0; k <= TBL_N; k++) begin
            x = (HALF_PI_Q30 * longint'(k)) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (n = 1; n <= 7; n++) begin
                term = div_small((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
                if ((n % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            q = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
            if (q > 32767) begin
                q = 32767;
            end
            r[k] = SINE_W'(q);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    blit_state_t state_reg, state_next;

    logic [SPS_W-1:0]      sps_reg;
    logic [HARM_W-1:0]     harm_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SINE_W-1:0]     rom_data_reg;
    logic [SINE_W-1:0]     den_reg;
    logic [SINE_W-1:0]     num_reg;
    logic                  neg_reg;
    logic                  near_reg;
    logic [DIVR_W-1:0]     div_reg;
    logic [DIVR_W-1:0]     rem_reg;
    logic [DVD_W-1:0]      quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  m_tvalid_reg;
    logic [SAMPLE_W-1:0]   m_tdata_reg;

    logic [MULT_W-1:0]     m_val;
    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [PROD_W-1:0]     mul_prod;
    logic [PHASE_BITS:0]   angle;
    logic [ADDR_W-1:0]     idx_raw;
    logic [ADDR_W-1:0]     rom_addr;
    logic [DIVR_W:0]       rem_shift;
    logic [DIVR_W:0]       rem_diff;
    logic                  q_bit;
    logic [SAMPLE_W-1:0]   result;
    logic                  out_load;

    assign cfg_ready = 1'b1;
    assign m_val     = {harm_reg, 1'b1};
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign mul_prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Operand selection for the shared multiplier and the sine ROM address.
    always_comb begin
        mul_a = MA_W'(m_val);
        mul_b = MB_W'(phase_reg);
        angle = {1'b0, phase_reg};
        case (state_reg)
            ST_LOOK_NUM: begin
                mul_b = MB_W'(rom_data_reg);
                angle = prod_reg[PHASE_BITS:0];
            end
            ST_INC: begin
                mul_a = freq_reg;
                mul_b = MB_W'(sps_reg);
            end
            default: begin
            end
        endcase
        idx_raw = angle[PHASE_BITS-1 -: ADDR_W];
        if ({1'b0, idx_raw} > TBL_N_X) begin
            rom_addr = ADDR_W'(TWO_N_X - {1'b0, idx_raw});
        end else begin
            rom_addr = idx_raw;
        end
    end

    // Divider step and final saturation.
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        q_bit     = (rem_shift >= {1'b0, div_reg});
        if (near_reg) begin
            result = SAMPLE_MAX;
        end else if (neg_reg) begin
            if (quo_reg > DVD_W'(32768)) begin
                result = SAMPLE_MIN;
            end else begin
                result = SAMPLE_W'(-quo_reg);
            end
        end else if (quo_reg > DVD_W'(32767)) begin
            result = SAMPLE_MAX;
        end else begin
            result = SAMPLE_W'(quo_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_MUL_ANGLE;
                end
            end
            ST_MUL_ANGLE: state_next = ST_LOOK_NUM;
            ST_LOOK_NUM:  state_next = ST_INC;
            ST_INC:       state_next = ST_PHASE;
            ST_PHASE: begin
                if (den_reg <= thr_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sps_reg      <= SPS_RESET;
            harm_reg     <= HARM_RESET;
            thr_reg      <= THR_RESET;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SECONDS_PER_SAMPLE:  sps_reg  <= cfg_data[SPS_W-1:0];
                    REG_HARMONIC_COUNT:      harm_reg <= cfg_data[HARM_W-1:0];
                    REG_NEAR_ZERO_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_PHASE) begin
                phase_reg <= phase_reg + prod_reg[INC_LSB +: PHASE_BITS];
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rom_data_reg <= SINE_ROM[rom_addr];
        if (s_tvalid && s_tready) begin
            freq_reg <= s_tdata[FREQ_W-1:0];
        end
        case (state_reg)
            ST_MUL_ANGLE: begin
                prod_reg <= mul_prod;
            end
            ST_LOOK_NUM: begin
                prod_reg <= mul_prod;
                den_reg  <= rom_data_reg;
                neg_reg  <= prod_reg[PHASE_BITS];
            end
            ST_INC: begin
                prod_reg <= mul_prod;
                num_reg  <= rom_data_reg;
                div_reg  <= prod_reg[DIVR_W-1:0];
            end
            ST_PHASE: begin
                near_reg <= (den_reg <= thr_reg);
                rem_reg  <= '0;
                quo_reg  <= {num_reg, 15'd0};
                cnt_reg  <= '0;
            end
            ST_DIV: begin
                if (q_bit) begin
                    rem_reg <= rem_diff[DIVR_W-1:0];
                end else begin
                    rem_reg <= rem_shift[DIVR_W-1:0];
                end
                quo_reg <= {quo_reg[DVD_W-2:0], q_bit};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_tdata_reg <= result;
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an earlier word is in progress");

    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (div_reg != '0))
        else $error("divider running with a zero divisor");

    a_phase_update_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_PHASE) |=> $stable(phase_reg))
        else $error("phase changed outside its update step");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench of the band-limited impulse train block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import blit_pkg::*;

    typedef longint unsigned u64_t;

    localparam int PHASE_BITS      = 24;
    localparam int SINE_TABLE_BITS = 10;
    localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
    localparam int STALL_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 64;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;

    int unsigned             quarter_wave [TABLE_SIZE+1];
    logic [PHASE_BITS-1:0]   model_phase = '0;
    logic [SPS_W-1:0]        model_sps   = SPS_RESET;
    logic [HARM_W-1:0]       model_harm  = HARM_RESET;
    logic [THR_W-1:0]        model_thr   = THR_RESET;
    logic [SAMPLE_W-1:0]     expected_samples [$];
    logic [SAMPLE_W-1:0]     wanted_sample;

    bandlimited_impulse_train #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The quarter-wave table is a truncated Taylor series in Q30, scaled to 32767.
    initial begin : fill_quarter_wave
        longint unsigned x, x2, term, q;
        longint          sum;
        for (int k = 0; k <= TABLE_SIZE; k++) begin
            x = (HALF_PI_Q30 * u64_t'(k)) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum -= longint'(term);
                end else begin
                    sum += longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            q = (u64_t'(sum) * 32767 + (64'd1 << 29)) >> 30;
            quarter_wave[k] = (q > 32767) ? 32767 : 32'(q);
        end
    end

    // The angle is in units of pi / 2^PHASE_BITS and is taken modulo two pi.
    function automatic int sine_of_angle(input longint unsigned angle);
        logic [PHASE_BITS:0] turn;
        longint unsigned     idx;
        turn = angle[PHASE_BITS:0];
        idx = turn[PHASE_BITS-1:0] >> (PHASE_BITS - SINE_TABLE_BITS - 1);
        if (idx > TABLE_SIZE) begin
            idx = 2 * TABLE_SIZE - idx;
        end
        return turn[PHASE_BITS] ? -int'(quarter_wave[idx]) : int'(quarter_wave[idx]);
    endfunction

    function automatic logic [SAMPLE_W-1:0] impulse_sample(input logic [PHASE_BITS-1:0] ph);
        longint unsigned m, mag, q;
        int              den, num;
        m = (u64_t'(model_harm) << 1) + 1;
        den = sine_of_angle(ph);
        if (den <= int'(model_thr)) begin
            return SAMPLE_MAX;
        end
        num = sine_of_angle(m * ph);
        mag = u64_t'(num < 0 ? -num : num);
        q = (mag << 15) / (m * u64_t'(den));
        if (num >= 0) begin
            return (q > 32767) ? SAMPLE_MAX : SAMPLE_W'(q);
        end
        return (q > 32768) ? SAMPLE_MIN : SAMPLE_W'(-q);
    endfunction

    // Predictions are made at the edge that accepts a word, from the phase held before it.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_samples.push_back(impulse_sample(model_phase));
            model_phase = model_phase + PHASE_BITS'(
                (u64_t'(s_tdata[FREQ_W-1:0]) * model_sps) >> (36 - PHASE_BITS));
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SECONDS_PER_SAMPLE: model_sps = cfg_data[SPS_W-1:0];
                REG_HARMONIC_COUNT: model_harm = cfg_data[HARM_W-1:0];
                REG_NEAR_ZERO_THRESHOLD: model_thr = cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("sample: expected no word, got %0d", $signed(m_tdata));
                mismatches++;
            end else begin
                wanted_sample = expected_samples.pop_front();
                if (m_tdata !== wanted_sample) begin
                    $error("sample: expected %0d, got %0d",
                           $signed(wanted_sample), $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_frequency(input logic [FREQ_W-1:0] freq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(freq);
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_for_samples();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [SPS_W-1:0] sps, input logic [HARM_W-1:0] harm,
                              input logic [THR_W-1:0] thr);
        wait_for_samples();
        write_register(REG_SECONDS_PER_SAMPLE, CFG_DATA_W'(sps));
        write_register(REG_HARMONIC_COUNT, CFG_DATA_W'(harm));
        write_register(REG_NEAR_ZERO_THRESHOLD, CFG_DATA_W'(thr));
    endtask

    // Phase starts at zero, so the first word hits the near-zero case.
    task automatic test_reset_defaults();
        send_frequency(19'd0);
        send_frequency(19'd1);
        send_frequency(19'd384000);
        send_frequency(19'h7FFFF);
        send_frequency(19'd0);
        send_frequency(19'h2AAAA);
        send_frequency(19'h55555);
        send_frequency(19'd1000);
    endtask

    // Extreme settings, including steps of more than pi that wrap several times.
    task automatic test_register_extremes();
        set_config(20'd536871, 10'd1023, 15'd0);
        send_frequency(19'h7FFFF);
        send_frequency(19'd384000);
        send_frequency(19'd1);
        send_frequency(19'd0);
        send_frequency(19'd262144);
        send_frequency(19'd12345);
        set_config(20'd44739, 10'd0, 15'd32767);
        send_frequency(19'd384000);
        send_frequency(19'h7FFFF);
        send_frequency(19'd7);
        set_config(SPS_RESET, 10'd1, 15'd1);
        send_frequency(19'd384000);
        send_frequency(19'd192000);
        send_frequency(19'd96000);
        send_frequency(19'd48000);
    endtask

    task automatic test_random_stream(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned count);
        logic [SPS_W-1:0]  sps;
        logic [HARM_W-1:0] harm;
        logic [THR_W-1:0]  thr;
        logic [FREQ_W-1:0] freq;
        case ($urandom_range(3))
            0: sps = 20'd44739;
            1: sps = 20'd536871;
            2: sps = SPS_W'($urandom_range(536871, 44739));
            default: sps = SPS_W'($urandom);
        endcase
        case ($urandom_range(3))
            0: harm = 10'd0;
            1: harm = 10'd1023;
            2: harm = HARM_W'($urandom_range(1023));
            default: harm = HARM_W'($urandom_range(8, 1));
        endcase
        case ($urandom_range(2))
            0: thr = 15'd0;
            1: thr = THR_W'($urandom_range(64));
            default: thr = THR_W'($urandom_range(2000));
        endcase
        set_config(sps, harm, thr);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            case ($urandom_range(9))
                0: freq = '0;
                1: freq = FREQ_W'($urandom_range(2000));
                2: freq = FREQ_W'($urandom);
                default: freq = FREQ_W'($urandom_range(384000));
            endcase
            send_frequency(freq);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_register_extremes();
        for (int round = 0; round < 2; round++) begin
            test_random_stream(0, 0, 190);
            test_random_stream(72, 0, 190);
            test_random_stream(0, 72, 190);
            test_random_stream(27, 27, 190);
        end
        wait_for_samples();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
